// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions on clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while out of reset.
`define DQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge while out of reset.
`define DQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// Deque package
// Command codes, status codes and transaction widths of the deque core.
// ---------------------------------------------------------------------------
package dq_pkg;

    // Command codes carried in the low bits of the input transaction.
    localparam logic [2:0] CMD_PUT_BACK   = 3'd0;
    localparam logic [2:0] CMD_PUT_FRONT  = 3'd1;
    localparam logic [2:0] CMD_TAKE_BACK  = 3'd2;
    localparam logic [2:0] CMD_TAKE_FRONT = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_QUERY      = 3'd5;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Transaction widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 112;

    typedef logic signed [WORD_W-1:0] word_t;

endpackage

// ===== hdl/double_ended_queue_core.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue core
// A command is registered into the response state, and its result is loaded into the
// output registers once the output is free; no new command is taken until then.
// A registered read of the word memory refreshes the front or back word after a pop.
// Reset clears the count, front index and cached end words; the word memory
// itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata: command [2:0], value [34:3], zero padding [39:35]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: popped_value [31:0], status [33:32], entry_count [44:34],
    //          front_value [76:45], back_value [108:77], zero padding [111:109]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W = (PW+1)'(DEPTH);
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    // Ring position of an offset from a base, both below DEPTH.
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                               input logic [PW-1:0] offset);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[PW-1:0];
    endfunction

    // Word memory.
    word_t mem [DEPTH];
    word_t mem_rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [PW-1:0] mem_waddr;
    logic [PW-1:0] mem_raddr;

    // Control and result registers.
    state_t        state_reg, state_next;
    logic [PW-1:0] front_idx_reg, front_idx_next;
    logic [CW-1:0] count_reg, count_next;
    word_t         front_reg, front_next;
    word_t         back_reg, back_next;
    logic          fix_front_reg, fix_front_next;
    logic          fix_back_reg, fix_back_next;
    word_t         popped_reg, popped_next;
    logic [1:0]    status_reg, status_next;

    logic               out_valid_reg, out_valid_next;
    word_t              out_popped_reg, out_popped_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    word_t              out_front_reg, out_front_next;
    word_t              out_back_reg, out_back_next;

    // Input fields.
    logic [CMD_W-1:0] cmd;
    word_t            val;
    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [CW-1:0]    count_dec;

    assign cmd       = s_tdata[CMD_W-1:0];
    assign val       = s_tdata[CMD_W+WORD_W-1:CMD_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_full   = (count_reg == FULL_COUNT);
    assign is_empty  = (count_reg == '0);
    assign count_dec = count_reg - CW'(1);

    // Command decode, pointer update and memory access.
    always_comb
    begin
        state_next     = state_reg;
        front_idx_next = front_idx_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        fix_front_next = fix_front_reg;
        fix_back_next  = fix_back_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;

        out_valid_next  = out_valid_reg && !m_tready;
        out_popped_next = out_popped_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    popped_next    = '0;
                    status_next    = STATUS_OK;
                    fix_front_next = 1'b0;
                    fix_back_next  = 1'b0;
                    state_next     = ST_RESP;
                    case (cmd)
                        CMD_PUT_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = ring_add(front_idx_reg, count_reg[PW-1:0]);
                                count_next = count_reg + CW'(1);
                                back_next  = val;
                                if (is_empty)
                                begin
                                    front_next = val;
                                end
                            end
                        end
                        CMD_PUT_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                front_idx_next = (front_idx_reg == '0) ? LAST_POS
                                                 : front_idx_reg - PW'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = front_idx_next;
                                count_next = count_reg + CW'(1);
                                front_next = val;
                                if (is_empty)
                                begin
                                    back_next = val;
                                end
                            end
                        end
                        CMD_TAKE_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                popped_next = back_reg;
                                count_next  = count_dec;
                                if (count_dec == '0)
                                begin
                                    front_next = '0;
                                    back_next  = '0;
                                end
                                else
                                begin
                                    // New back sits one below the old one.
                                    mem_re        = 1'b1;
                                    mem_raddr     = ring_add(front_idx_reg,
                                                             PW'(count_dec - CW'(1)));
                                    fix_back_next = 1'b1;
                                end
                            end
                        end
                        CMD_TAKE_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                popped_next    = front_reg;
                                count_next     = count_dec;
                                front_idx_next = (front_idx_reg == LAST_POS) ? '0
                                                 : front_idx_reg + PW'(1);
                                if (count_dec == '0)
                                begin
                                    front_next = '0;
                                    back_next  = '0;
                                end
                                else
                                begin
                                    mem_re         = 1'b1;
                                    mem_raddr      = front_idx_next;
                                    fix_front_next = 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            front_next = '0;
                            back_next  = '0;
                        end
                        default:
                        begin
                            // Query and unused codes leave the count and stored words alone.
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                // Fold the word just read into the cached end.
                if (fix_front_reg)
                begin
                    front_next = mem_rdata_reg;
                end
                if (fix_back_reg)
                begin
                    back_next = mem_rdata_reg;
                end
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_popped_next = popped_reg;
                    out_status_next = status_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    out_front_next  = front_next;
                    out_back_next   = back_next;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            front_idx_reg   <= '0;
            count_reg       <= '0;
            front_reg       <= '0;
            back_reg        <= '0;
            fix_front_reg   <= 1'b0;
            fix_back_reg    <= 1'b0;
            popped_reg      <= '0;
            status_reg      <= STATUS_OK;
            out_valid_reg   <= 1'b0;
            out_popped_reg  <= '0;
            out_status_reg  <= STATUS_OK;
            out_count_reg   <= '0;
            out_front_reg   <= '0;
            out_back_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            front_idx_reg   <= front_idx_next;
            count_reg       <= count_next;
            front_reg       <= front_next;
            back_reg        <= back_next;
            fix_front_reg   <= fix_front_next;
            fix_back_reg    <= fix_back_next;
            popped_reg      <= popped_next;
            status_reg      <= status_next;
            out_valid_reg   <= out_valid_next;
            out_popped_reg  <= out_popped_next;
            out_status_reg  <= out_status_next;
            out_count_reg   <= out_count_next;
            out_front_reg   <= out_front_next;
            out_back_reg    <= out_back_next;
        end
    end

    // Word memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= val;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Output transaction.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_back_reg, out_front_reg, out_count_reg,
                       out_status_reg, out_popped_reg};

    // Checks.
    `DQ_ASSERT(a_count_bound, count_reg <= FULL_COUNT, "entry count exceeds depth")
    `DQ_ASSERT_IMP(a_one_in_flight, accept, ##1 !s_tready, "command taken while busy")
    `DQ_ASSERT_IMP(a_empty_ends_zero, count_reg == '0 && !fix_front_reg && !fix_back_reg,
                   front_reg == '0 && back_reg == '0, "empty queue holds stale end words")
    `DQ_ASSERT_IMP(a_single_fix, state_reg == ST_RESP, !(fix_front_reg && fix_back_reg),
                   "both ends pending a memory read")

endmodule
